// File: hdl/stb_pkg.sv
package stb_pkg;

	// Default number of timer slots in the table.
	localparam int NUM_TIMERS_DEF = 16;

	// Slots that the four-bit slot field can reach; allocation searches only these.
	localparam int SLOT_W = 4;
	localparam int ADDR_SLOTS_MAX = 16;

	localparam int OPCODE_W = 4;
	localparam int DUR_W = 16;
	localparam int SCALE_W = 15;
	localparam int VAL_W = 32;
	localparam int TICK_W = 16;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TICK_PERIOD = 1'b0;
	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd1;

	// Divider runs one quotient bit per cycle.
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK     = 4'd0,
		OP_START    = 4'd1,
		OP_RESTART  = 4'd2,
		OP_STOP     = 4'd3,
		OP_SUSPEND  = 4'd4,
		OP_RESUME   = 4'd5,
		OP_QUERY    = 4'd6,
		OP_ALLOCATE = 4'd7,
		OP_RELEASE  = 4'd8
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC,
		ST_MUL,
		ST_RD,
		ST_LOAD,
		ST_QDIV,
		ST_DIVW,
		ST_TICK,
		ST_EXEC,
		ST_FIN
	} state_t;

	// One word of the timer memory.
	typedef struct packed {
		logic signed [VAL_W-1:0] count;
		logic signed [VAL_W-1:0] preset;
		logic signed [VAL_W-1:0] remain;
		logic [SCALE_W-1:0]      scale;
	} entry_t;

	// Per-slot status flags.
	typedef struct packed {
		logic in_use;
		logic run;
		logic pause;
		logic expired;
	} flags_t;

endpackage

// File: hdl/stb_if.sv
interface stb_cmd_if import stb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OPCODE_W-1:0] opcode;
	logic [SLOT_W-1:0]  slot;
	logic [DUR_W-1:0]   duration;
	logic [SCALE_W-1:0] scale;

	modport source (output valid, opcode, slot, duration, scale, input ready);
	modport sink (input valid, opcode, slot, duration, scale, output ready);
endinterface

interface stb_rsp_if import stb_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic                    status;
	logic [SLOT_W-1:0]       slot_out;
	logic signed [VAL_W-1:0] time_left_scaled;
	logic                    is_active;
	logic                    is_suspended;
	logic                    is_expired;
	logic [ADDR_SLOTS_MAX-1:0] expired_mask;

	modport source (output valid, status, slot_out, time_left_scaled, is_active,
		is_suspended, is_expired, expired_mask, input ready);
	modport sink (input valid, status, slot_out, time_left_scaled, is_active,
		is_suspended, is_expired, expired_mask, output ready);
endinterface

// File: hdl/software_timer_bank.sv
// Bank of countdown timer slots.
//
// Commands arrive as words on the cmd channel (valid/ready); each command
// produces exactly one response word on the rsp channel. Commands are taken
// one at a time: cmd.ready is high only while the sequencer is idle.
// The tick period is written through the APB-style port at byte address 0;
// writes are expected only while no command is in flight.
//
// All per-slot values (count, preset, remaining time, stored scale) sit in
// one synchronous memory with a registered read; the four status flags of
// each slot are flip-flops. Steps from acceptance to the response register:
//   tick              a walk over all slots, one slot read per cycle, write-back overlapped
//   query             read, bit-serial divide if divisor nonzero; neither on a free slot
//   start, restart    multiply or read, then load; neither on a free slot
//   other commands    an execute step; undefined opcodes skip it
// The next command can be taken in the cycle after the response register loads.
// A new command is accepted while an earlier response still waits in the
// output register; the sequencer then holds its result until rsp.ready.
// Reset clears the flags (all slots free), the tick period to 1 and the
// channels; the memory needs no clearing since allocation writes the slot.
module software_timer_bank import stb_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	stb_cmd_if.sink            cmd,
	stb_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int ADDR_SLOTS = (NUM_TIMERS < ADDR_SLOTS_MAX) ? NUM_TIMERS : ADDR_SLOTS_MAX;

	// Configuration register.
	logic [TICK_W-1:0] tick_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_PERIOD_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_TICK_PERIOD) begin
			tick_q <= pwdata[TICK_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TICK_PERIOD) ? {{(PDATA_W-TICK_W){1'b0}}, tick_q} : '0;

	logic signed [VAL_W-1:0] tick_s;
	assign tick_s = $signed({{(VAL_W-TICK_W){1'b0}}, tick_q});

	// Sequencer state and the latched command.
	state_t state_q, state_nx;
	logic [OPCODE_W-1:0] op_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [DUR_W-1:0]    dur_q;
	logic [SCALE_W-1:0]  scl_q;

	// Per-slot flags.
	logic [NUM_TIMERS-1:0] in_use_q;
	logic [NUM_TIMERS-1:0] run_q;
	logic [NUM_TIMERS-1:0] pause_q;
	logic [NUM_TIMERS-1:0] exp_q;

	// Timer memory.
	entry_t mem_q [NUM_TIMERS];
	entry_t mem_rdata_s1;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_wdata;

	// Flag write port, one slot per cycle.
	logic             fl_we;
	logic [IDX_W-1:0] fl_idx;
	flags_t           fl_new;

	// Tick walk: issue counter, then the slot whose read data is back.
	logic [CNT_W-1:0] issue_q;
	logic             tv_s1;
	logic [IDX_W-1:0] tidx_s1;
	logic             tick_issue;

	// Multiply stage of start.
	logic [DUR_W+SCALE_W-1:0] prod_w;
	logic signed [VAL_W-1:0]  prod_s1;

	// Divider.
	logic                    div_start;
	logic                    div_done;
	logic signed [VAL_W-1:0] div_quot;
	logic [SCALE_W-1:0]      div_den;

	// Result under construction.
	logic                    status_q;
	logic [SLOT_W-1:0]       where_q;
	logic signed [VAL_W-1:0] q_q;

	// Response register.
	logic                      rsp_valid_q;
	logic                      rsp_status_q;
	logic [SLOT_W-1:0]         rsp_slot_q;
	logic signed [VAL_W-1:0]   rsp_tls_q;
	logic                      rsp_act_q;
	logic                      rsp_sus_q;
	logic                      rsp_exp_q;
	logic [ADDR_SLOTS_MAX-1:0] rsp_mask_q;

	logic             cmd_acc;
	logic             rsp_load;
	logic [IDX_W-1:0] slot_idx;
	logic             ok;
	logic             alloc_found;
	logic [SLOT_W-1:0] alloc_slot;
	logic [IDX_W-1:0] alloc_idx;
	logic [IDX_W-1:0] where_idx;
	logic [ADDR_SLOTS_MAX-1:0] mask_w;
	flags_t           cur_slot;
	flags_t           cur_tick;
	entry_t           load_e;
	entry_t           tick_e;
	logic signed [VAL_W-1:0] load_preset;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc = cmd.valid && cmd.ready;
	assign rsp_load = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	// The addressed slot exists and has been allocated.
	assign slot_idx = IDX_W'(slot_q);
	assign ok = (slot_q < NUM_TIMERS) && in_use_q[slot_idx];

	assign cur_slot = '{in_use: in_use_q[slot_idx], run: run_q[slot_idx],
		pause: pause_q[slot_idx], expired: exp_q[slot_idx]};
	assign cur_tick = '{in_use: in_use_q[tidx_s1], run: run_q[tidx_s1],
		pause: pause_q[tidx_s1], expired: exp_q[tidx_s1]};

	// Lowest free slot among those the slot field can address.
	always_comb begin
		alloc_found = 1'b0;
		alloc_slot = '0;
		for (int i = 0; i < ADDR_SLOTS; i++) begin
			if (!alloc_found && !in_use_q[i]) begin
				alloc_found = 1'b1;
				alloc_slot = SLOT_W'(i);
			end
		end
	end
	assign alloc_idx = IDX_W'(alloc_slot);

	// Start and restart both reload the count from the preset.
	always_comb begin
		load_preset = (op_q == OP_START) ? prod_s1 : mem_rdata_s1.preset;
		load_e.preset = load_preset;
		load_e.scale = (op_q == OP_START) ? scl_q : mem_rdata_s1.scale;
		load_e.count = load_preset - tick_s;
		load_e.remain = load_preset - tick_s;
	end

	// A running slot with a positive count loses one period; otherwise it expires.
	always_comb begin
		tick_e = mem_rdata_s1;
		if (mem_rdata_s1.count > 0) begin
			tick_e.count = mem_rdata_s1.count - tick_s;
			tick_e.remain = mem_rdata_s1.count - tick_s;
		end else begin
			tick_e.remain = '0;
		end
	end

	assign div_den = (scl_q != '0) ? scl_q : mem_rdata_s1.scale;
	assign tick_issue = (issue_q < CNT_W'(NUM_TIMERS));

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) state_nx = ST_DEC;
			end
			ST_DEC: begin
				case (op_q)
					OP_TICK: state_nx = ST_TICK;
					OP_START: state_nx = ok ? ST_MUL : ST_FIN;
					OP_RESTART, OP_QUERY: state_nx = ok ? ST_RD : ST_FIN;
					OP_STOP, OP_SUSPEND, OP_RESUME, OP_ALLOCATE, OP_RELEASE:
						state_nx = ST_EXEC;
					default: state_nx = ST_FIN;
				endcase
			end
			ST_MUL: state_nx = ST_LOAD;
			ST_RD: state_nx = (op_q == OP_QUERY) ? ST_QDIV : ST_LOAD;
			ST_LOAD: state_nx = ST_FIN;
			ST_QDIV: state_nx = (div_den == '0) ? ST_FIN : ST_DIVW;
			ST_DIVW: begin
				if (div_done) state_nx = ST_FIN;
			end
			ST_TICK: begin
				if (!tick_issue && !tv_s1) state_nx = ST_FIN;
			end
			ST_EXEC: state_nx = ST_FIN;
			ST_FIN: begin
				if (rsp_load) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Memory, flag and divider controls.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = slot_idx;
		mem_wdata = load_e;
		mem_raddr = slot_idx;
		fl_we = 1'b0;
		fl_idx = slot_idx;
		fl_new = cur_slot;
		div_start = 1'b0;
		case (state_q)
			ST_LOAD: begin
				mem_we = 1'b1;
				fl_we = 1'b1;
				fl_new.run = 1'b1;
				fl_new.pause = 1'b0;
				fl_new.expired = 1'b0;
			end
			ST_QDIV: begin
				div_start = (div_den != '0);
			end
			ST_TICK: begin
				mem_raddr = issue_q[IDX_W-1:0];
				mem_waddr = tidx_s1;
				mem_wdata = tick_e;
				fl_idx = tidx_s1;
				fl_new = cur_tick;
				if (tv_s1 && cur_tick.in_use && cur_tick.run && !cur_tick.pause) begin
					mem_we = 1'b1;
					if (!(mem_rdata_s1.count > 0)) begin
						fl_we = 1'b1;
						fl_new.expired = 1'b1;
						fl_new.run = 1'b0;
					end
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_STOP: begin
						fl_we = ok;
						fl_new.run = 1'b0;
						fl_new.expired = 1'b1;
					end
					OP_SUSPEND: begin
						fl_we = ok;
						fl_new.pause = 1'b1;
					end
					OP_RESUME: begin
						fl_we = ok;
						fl_new.pause = 1'b0;
					end
					OP_RELEASE: begin
						fl_we = ok;
						fl_new = '0;
					end
					OP_ALLOCATE: begin
						// The slot is cleared as it is claimed.
						fl_we = alloc_found;
						fl_idx = alloc_idx;
						fl_new = '{in_use: 1'b1, run: 1'b0, pause: 1'b0, expired: 1'b0};
						mem_we = alloc_found;
						mem_waddr = alloc_idx;
						mem_wdata = '0;
					end
					default: begin
						fl_we = 1'b0;
					end
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q <= cmd.opcode;
			slot_q <= cmd.slot;
			dur_q <= cmd.duration;
			scl_q <= cmd.scale;
		end
	end

	// Flags reset to all slots free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			run_q <= '0;
			pause_q <= '0;
			exp_q <= '0;
		end else if (fl_we) begin
			in_use_q[fl_idx] <= fl_new.in_use;
			run_q[fl_idx] <= fl_new.run;
			pause_q[fl_idx] <= fl_new.pause;
			exp_q[fl_idx] <= fl_new.expired;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		mem_rdata_s1 <= mem_q[mem_raddr];
	end

	// Tick walk: reads run one slot ahead of write-back, never on the same slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			tv_s1 <= 1'b0;
		end else if (state_q == ST_DEC) begin
			issue_q <= '0;
			tv_s1 <= 1'b0;
		end else if (state_q == ST_TICK) begin
			tv_s1 <= tick_issue;
			if (tick_issue) issue_q <= issue_q + 1'b1;
		end else begin
			tv_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		tidx_s1 <= issue_q[IDX_W-1:0];
	end

	assign prod_w = dur_q * scl_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_s1 <= $signed({{(VAL_W-DUR_W-SCALE_W){1'b0}}, prod_w});
		end
	end

	stb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mem_rdata_s1.remain),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Result fields gathered while the command runs.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			status_q <= 1'b0;
			where_q <= cmd.slot;
			q_q <= '0;
		end else begin
			if (state_q == ST_EXEC && op_q == OP_ALLOCATE) begin
				status_q <= !alloc_found;
				where_q <= alloc_slot;
			end
			if (state_q == ST_DIVW && div_done) begin
				q_q <= div_quot;
			end
		end
	end

	// Flags of the reported slot and the expired mask, taken after the update.
	assign where_idx = IDX_W'(where_q);

	generate
		for (genvar g = 0; g < ADDR_SLOTS_MAX; g++) begin : g_mask
			if (g < NUM_TIMERS) begin : g_real
				assign mask_w[g] = exp_q[g];
			end else begin : g_none
				assign mask_w[g] = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_slot_q <= where_q;
			rsp_tls_q <= q_q;
			rsp_act_q <= (where_q < NUM_TIMERS) && run_q[where_idx];
			rsp_sus_q <= (where_q < NUM_TIMERS) && pause_q[where_idx];
			rsp_exp_q <= (where_q < NUM_TIMERS) && exp_q[where_idx];
			rsp_mask_q <= mask_w;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.slot_out = rsp_slot_q;
	assign rsp.time_left_scaled = rsp_tls_q;
	assign rsp.is_active = rsp_act_q;
	assign rsp.is_suspended = rsp_sus_q;
	assign rsp.is_expired = rsp_exp_q;
	assign rsp.expired_mask = rsp_mask_q;

	// A fresh response only follows the final step of a command.
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("response raised outside the final step");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVW)
		else $error("divider finished outside a query");

	// A slot that is not allocated never runs or pauses.
	a_free_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((run_q | pause_q) & ~in_use_q) == '0)
		else $error("free slot has running or paused flag");

	// A failed allocation reports slot zero and no quotient.
	a_alloc_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q |-> rsp_slot_q == '0 && rsp_tls_q == '0)
		else $error("failed allocation reports a slot or value");

endmodule

// File: hdl/stb_div.sv
module stb_div import stb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VAL_W-1:0] dividend,
	input  logic [SCALE_W-1:0]      divisor,
	output logic                    done,
	output logic signed [VAL_W-1:0] quotient
);

	// Restoring division of the magnitude, one bit per cycle; the sign is
	// applied at the end so the quotient truncates toward zero.
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [VAL_W-1:0]     mag_q;
	logic [SCALE_W-1:0]   rem_q;
	logic [SCALE_W-1:0]   den_q;

	logic [SCALE_W:0] rem_sh;
	logic [SCALE_W:0] rem_nx;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q, mag_q[VAL_W-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[VAL_W-1];
			mag_q <= dividend[VAL_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx[SCALE_W-1:0];
			mag_q <= {mag_q[VAL_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// File: verif/testbench.sv
module testbench;
	import stb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Table size of the instance and the slots that allocation can reach.
	localparam int SLOTS = NUM_TIMERS_DEF;
	localparam int ALLOC_SLOTS = (SLOTS < ADDR_SLOTS_MAX) ? SLOTS : ADDR_SLOTS_MAX;

	// Opcodes above the last defined one do nothing.
	localparam logic [OPCODE_W-1:0] OP_FIRST_UNDEFINED = 4'd9;
	localparam logic [OPCODE_W-1:0] OP_LAST_UNDEFINED = 4'd15;

	// Byte address of the tick period register.
	localparam logic [PADDR_W-1:0] TICK_PERIOD_ADDR = PADDR_W'(REG_TICK_PERIOD) << 2;

	// A run with no accepted word for this many cycles is declared hung.
	localparam int HANG_LIMIT = 5000;

	// Cycles allowed after the last response for anything unexpected to show up.
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [SLOT_W-1:0]   slot;
		logic [DUR_W-1:0]    duration;
		logic [SCALE_W-1:0]  scale;
	} cmd_word_t;

	typedef struct packed {
		logic                      status;
		logic [SLOT_W-1:0]         slot_out;
		logic signed [VAL_W-1:0]   time_left_scaled;
		logic                      is_active;
		logic                      is_suspended;
		logic                      is_expired;
		logic [ADDR_SLOTS_MAX-1:0] expired_mask;
	} rsp_word_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	stb_cmd_if cmd_if();
	stb_rsp_if rsp_if();

	software_timer_bank dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Command words waiting for the driver, and the responses predicted for
	// commands that the block has already taken, oldest first.
	cmd_word_t pending_words[$];
	rsp_word_t predicted_rsp[$];

	int error_count = 0;
	int idle_cycles = 0;
	logic cmd_taken = 1'b0;

	// Percentages of cycles in which the sender holds back a word and the
	// receiver refuses one. The stimulus process changes them per phase.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Shadow copy of the timer table and of the tick period register.
	logic [TICK_W-1:0]  tick_period_shadow = TICK_PERIOD_RST;
	logic [SLOTS-1:0]   slot_used = '0;
	logic [SLOTS-1:0]   slot_running = '0;
	logic [SLOTS-1:0]   slot_paused = '0;
	logic [SLOTS-1:0]   slot_expired = '0;
	int                 slot_count[SLOTS];
	int                 slot_preset[SLOTS];
	int                 slot_remain[SLOTS];
	logic [SCALE_W-1:0] slot_scale[SLOTS];

	// The clock runs free: 4 ns high, 4 ns low.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report_mismatch(string field, longint got, longint want);
		$display("%0t mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
		error_count++;
	endtask

	// Puts a slot back into the state it has right after reset.
	function automatic void clear_slot(int s);
		slot_used[s] = 1'b0;
		slot_running[s] = 1'b0;
		slot_paused[s] = 1'b0;
		slot_expired[s] = 1'b0;
		slot_count[s] = 0;
		slot_preset[s] = 0;
		slot_remain[s] = 0;
		slot_scale[s] = '0;
	endfunction

	// The count starts one tick period below the preset, because the first
	// tick only arrives a full period after the start.
	function automatic void reload_count(int s);
		slot_count[s] = slot_preset[s] - int'(tick_period_shadow);
		slot_remain[s] = slot_count[s];
		slot_paused[s] = 1'b0;
		slot_expired[s] = 1'b0;
		slot_running[s] = 1'b1;
	endfunction

	// Applies one command to the shadow table and returns the response word
	// that the block must give for it.
	function automatic rsp_word_t predict_timer_response(cmd_word_t c);
		rsp_word_t r;
		logic      ok;
		logic      found;
		int        divisor;
		int        s;
		r = '0;
		r.slot_out = c.slot;
		ok = (int'(c.slot) < SLOTS) && slot_used[c.slot];
		case (c.opcode)
			OP_TICK: begin
				for (s = 0; s < SLOTS; s++) begin
					if (slot_used[s] && slot_running[s] && !slot_paused[s]) begin
						if (slot_count[s] > 0) begin
							slot_count[s] -= int'(tick_period_shadow);
							slot_remain[s] = slot_count[s];
						end else begin
							slot_remain[s] = 0;
							slot_expired[s] = 1'b1;
							slot_running[s] = 1'b0;
						end
					end
				end
			end
			OP_START: begin
				if (ok) begin
					slot_preset[c.slot] = int'(32'(c.duration) * 32'(c.scale));
					slot_scale[c.slot] = c.scale;
					reload_count(int'(c.slot));
				end
			end
			OP_RESTART: begin
				if (ok)
					reload_count(int'(c.slot));
			end
			OP_STOP: begin
				if (ok) begin
					slot_running[c.slot] = 1'b0;
					slot_expired[c.slot] = 1'b1;
				end
			end
			OP_SUSPEND: begin
				if (ok)
					slot_paused[c.slot] = 1'b1;
			end
			OP_RESUME: begin
				if (ok)
					slot_paused[c.slot] = 1'b0;
			end
			OP_QUERY: begin
				if (ok) begin
					// A zero scale in the command selects the scale stored at start.
					divisor = (c.scale != '0) ? int'(c.scale) : int'(slot_scale[c.slot]);
					if (divisor != 0)
						r.time_left_scaled = slot_remain[c.slot] / divisor;
				end
			end
			OP_ALLOCATE: begin
				r.status = 1'b1;
				r.slot_out = '0;
				found = 1'b0;
				for (s = 0; s < ALLOC_SLOTS; s++) begin
					if (!found && !slot_used[s]) begin
						clear_slot(s);
						slot_used[s] = 1'b1;
						r.status = 1'b0;
						r.slot_out = SLOT_W'(s);
						found = 1'b1;
					end
				end
			end
			OP_RELEASE: begin
				if (ok)
					clear_slot(int'(c.slot));
			end
			default: begin
			end
		endcase
		for (s = 0; s < ALLOC_SLOTS; s++)
			r.expired_mask[s] = slot_expired[s];
		if (int'(r.slot_out) < SLOTS) begin
			r.is_active = slot_running[r.slot_out];
			r.is_suspended = slot_paused[r.slot_out];
			r.is_expired = slot_expired[r.slot_out];
		end
		return r;
	endfunction

	// Driver. Everything changes at the falling edge so that the block sees
	// stable inputs at the rising edge. A word stays on the channel until the
	// edge that takes it; only then may the next word (or a gap) follow.
	always @(negedge clk) begin
		cmd_word_t w;
		if (arst_n) begin
			if (!cmd_if.valid || cmd_taken) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					w = pending_words.pop_front();
					cmd_if.valid <= 1'b1;
					cmd_if.opcode <= w.opcode;
					cmd_if.slot <= w.slot;
					cmd_if.duration <= w.duration;
					cmd_if.scale <= w.scale;
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor. Both channels are sampled at the rising edge, before the block
	// updates its registers for that edge. A taken command is run through the
	// predictor at once; a taken response is checked against the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		rsp_word_t got;
		rsp_word_t want;
		logic      moved;
		if (arst_n) begin
			moved = 1'b0;
			cmd_taken <= cmd_if.valid && cmd_if.ready;
			if (rsp_if.valid && rsp_if.ready) begin
				moved = 1'b1;
				got.status = rsp_if.status;
				got.slot_out = rsp_if.slot_out;
				got.time_left_scaled = rsp_if.time_left_scaled;
				got.is_active = rsp_if.is_active;
				got.is_suspended = rsp_if.is_suspended;
				got.is_expired = rsp_if.is_expired;
				got.expired_mask = rsp_if.expired_mask;
				if (predicted_rsp.size() == 0) begin
					report_mismatch("responses outstanding", 1, 0);
				end else begin
					want = predicted_rsp.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.slot_out !== want.slot_out)
						report_mismatch("slot_out", got.slot_out, want.slot_out);
					if (got.time_left_scaled !== want.time_left_scaled)
						report_mismatch("time_left_scaled", got.time_left_scaled,
							want.time_left_scaled);
					if (got.is_active !== want.is_active)
						report_mismatch("is_active", got.is_active, want.is_active);
					if (got.is_suspended !== want.is_suspended)
						report_mismatch("is_suspended", got.is_suspended, want.is_suspended);
					if (got.is_expired !== want.is_expired)
						report_mismatch("is_expired", got.is_expired, want.is_expired);
					if (got.expired_mask !== want.expired_mask)
						report_mismatch("expired_mask", got.expired_mask, want.expired_mask);
				end
			end
			if (cmd_if.valid && cmd_if.ready) begin
				moved = 1'b1;
				predicted_rsp.push_back(predict_timer_response({cmd_if.opcode, cmd_if.slot,
					cmd_if.duration, cmd_if.scale}));
			end
			// Watchdog: a block that stops taking or giving words ends the run.
			if (moved) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= HANG_LIMIT) begin
				$display("%0t no word moved for %0d cycles", $realtime, HANG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_word(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] slot,
		logic [DUR_W-1:0] dur, logic [SCALE_W-1:0] scl);
		pending_words.push_back({op, slot, dur, scl});
	endtask

	// Waits until every queued command has been taken and answered.
	task automatic wait_until_drained();
		while (pending_words.size() != 0 || predicted_rsp.size() != 0 || cmd_if.valid)
			@(posedge clk);
	endtask

	// Writes the tick period through the register port and reads it back.
	// Only called while no command is in flight, so the shadow copy may be
	// updated at the very edge that writes the register.
	task automatic program_tick_period(logic [TICK_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= TICK_PERIOD_ADDR;
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tick_period_shadow = value;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== PDATA_W'(value))
			report_mismatch("prdata", prdata, PDATA_W'(value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random commands. Slots are drawn mostly from the low end of the table,
	// where allocation puts them, and start mostly uses short timers so that
	// ticks actually drive slots into expiry. Now and then a burst of
	// allocations fills the table so that allocation also fails.
	task automatic queue_random_words(int count);
		cmd_word_t w;
		int        pick;
		int        k;
		int        n;
		n = 0;
		while (n < count) begin
			w.opcode = OPCODE_W'($urandom);
			w.slot = ($urandom_range(99) < 70) ? SLOT_W'($urandom_range(7)) : SLOT_W'($urandom);
			w.duration = DUR_W'($urandom);
			w.scale = SCALE_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 2) begin
				for (k = 0; k <= ALLOC_SLOTS; k++)
					push_word(OP_ALLOCATE, SLOT_W'($urandom), DUR_W'($urandom),
						SCALE_W'($urandom));
				n += ALLOC_SLOTS + 1;
				continue;
			end else if (pick < 12) begin
				w.opcode = OP_ALLOCATE;
			end else if (pick < 17) begin
				w.opcode = OP_RELEASE;
			end else if (pick < 32) begin
				w.opcode = OP_START;
				if ($urandom_range(99) < 80) begin
					w.duration = DUR_W'($urandom_range(12));
					w.scale = SCALE_W'($urandom_range(4));
				end
			end else if (pick < 37) begin
				w.opcode = OP_RESTART;
			end else if (pick < 42) begin
				w.opcode = OP_STOP;
			end else if (pick < 48) begin
				w.opcode = OP_SUSPEND;
			end else if (pick < 54) begin
				w.opcode = OP_RESUME;
			end else if (pick < 70) begin
				w.opcode = OP_QUERY;
				k = $urandom_range(99);
				if (k < 50)
					w.scale = '0;
				else if (k < 80)
					w.scale = SCALE_W'($urandom_range(1, 8));
			end else if (pick < 96) begin
				w.opcode = OP_TICK;
			end else begin
				w.opcode = OPCODE_W'($urandom_range(OP_FIRST_UNDEFINED, OP_LAST_UNDEFINED));
			end
			pending_words.push_back(w);
			n++;
		end
	endtask

	initial begin
		// Every input of the block has a known value from time zero.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.opcode = '0;
		cmd_if.slot = '0;
		cmd_if.duration = '0;
		cmd_if.scale = '0;
		rsp_if.ready = 1'b0;
		for (int s = 0; s < SLOTS; s++)
			clear_slot(s);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset tick period of 1, with no idling.
		// Commands to a slot that was never allocated must do nothing.
		push_word(OP_QUERY, 4'd0, 16'd0, 15'd1);
		push_word(OP_START, 4'd0, 16'd5, 15'd5);
		push_word(OP_ALLOCATE, 4'd9, 16'd0, 15'd0);
		// Preset 6, count 5; query with the stored scale and with one given.
		push_word(OP_START, 4'd0, 16'd2, 15'd3);
		push_word(OP_QUERY, 4'd0, 16'd0, 15'd0);
		push_word(OP_QUERY, 4'd0, 16'd0, 15'd4);
		// A suspended slot keeps its count across a tick.
		push_word(OP_SUSPEND, 4'd0, 16'd0, 15'd0);
		push_word(OP_TICK, 4'd0, 16'd0, 15'd0);
		push_word(OP_RESUME, 4'd0, 16'd0, 15'd0);
		push_word(OP_TICK, 4'd0, 16'd0, 15'd0);
		// A zero-length timer starts below zero: the query is negative, the
		// stored scale is zero, and the next tick expires it.
		push_word(OP_ALLOCATE, 4'd0, 16'd0, 15'd0);
		push_word(OP_START, 4'd1, 16'd0, 15'd0);
		push_word(OP_QUERY, 4'd1, 16'd0, 15'd1);
		push_word(OP_QUERY, 4'd1, 16'd0, 15'd0);
		push_word(OP_TICK, 4'd0, 16'd0, 15'd0);
		push_word(OP_RESTART, 4'd1, 16'd0, 15'd0);
		push_word(OP_STOP, 4'd0, 16'd0, 15'd0);
		push_word(OP_RELEASE, 4'd1, 16'd0, 15'd0);
		// Largest duration times largest scale.
		push_word(OP_START, 4'd0, 16'hFFFF, 15'h7FFF);
		push_word(OP_QUERY, 4'd0, 16'd0, 15'h7FFF);
		push_word(OP_QUERY, 4'd0, 16'hFFFF, 15'd1);
		// Undefined opcodes report like a tick that does nothing.
		push_word(OP_LAST_UNDEFINED, 4'd15, 16'hFFFF, 15'h7FFF);
		push_word(OP_FIRST_UNDEFINED, 4'd0, 16'd0, 15'd0);
		push_word(OP_RELEASE, 4'd0, 16'd0, 15'd0);
		push_word(OP_SUSPEND, 4'd15, 16'd0, 15'd0);
		wait_until_drained();

		// Random phases, with varied tick periods and idling patterns.
		// The largest period expires a started slot on almost every tick, and
		// a zero period freezes every count.
		program_tick_period(TICK_PERIOD_RST);
		queue_random_words(125);
		wait_until_drained();

		program_tick_period(16'hFFFF);
		send_idle_pct = 87;
		queue_random_words(125);
		wait_until_drained();

		program_tick_period(16'd0);
		send_idle_pct = 0;
		recv_stall_pct = 87;
		queue_random_words(125);
		wait_until_drained();

		program_tick_period(TICK_W'($urandom_range(1, 16)));
		send_idle_pct = 16;
		recv_stall_pct = 16;
		queue_random_words(125);
		wait_until_drained();

		program_tick_period(TICK_W'($urandom_range(1, 16'hFFFF)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random_words(125);
		wait_until_drained();

		// Leave room for a stray response before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && predicted_rsp.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/stb_pkg.sv
hdl/stb_if.sv
hdl/stb_div.sv
hdl/software_timer_bank.sv
verif/testbench.sv
